/* src/nft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nft_pkg
// Shared types and constants of the flow table.
// ----------------------------------------------------------------------------
package nft_pkg;
  localparam int unsigned FlowCapacity = 1024;
  localparam logic [31:0] IdleTimeoutRst = 32'd1800;
  localparam logic [31:0] PurgePeriodRst = 32'd3600;
  localparam logic [7:0] ProtoTcp = 8'd6;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotTcp = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;

  localparam logic CfgIdleTimeout = 1'b0;
  localparam logic CfgPurgePeriod = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_FREE,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

/* src/nat_flow_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_flow_table
// Connection-tracking table for a TCP address rewriter.
// ----------------------------------------------------------------------------
// Non-TCP requests go straight to the result; others scan the table memory,
// one entry per cycle, stopping at the first hit or after the last entry.
// The lowest free entry is noted during the scan, so an insert adds the FREE
// state and, when due, an aging sweep over the whole table before it. One
// request at a time; a stalled result holds the block in DONE. Reset clears
// valid bits, count and sweep time.
module nat_flow_table #(
  parameter int unsigned FLOW_CAPACITY = nft_pkg::FlowCapacity
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode, protocol, src_ip, dst_ip, src_port, dst_port, target_ip,
  // target_port, forward_tag, now_seconds (lowest bit up), zero pad
  input  wire logic [223:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, out_src_ip, out_dst_ip, out_src_port, out_dst_port, return_tag
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int AW = (FLOW_CAPACITY > 1) ? $clog2(FLOW_CAPACITY) : 1;
  localparam int CW = $clog2(FLOW_CAPACITY + 1);
  localparam logic [AW:0] LAST = (AW+1)'(FLOW_CAPACITY - 1);

  // Entry: client ip, server ip, ports, origin, handle.
  logic [175:0] ent_mem [FLOW_CAPACITY];
  logic [31:0]  stamp_mem [FLOW_CAPACITY];
  logic [FLOW_CAPACITY-1:0] valid_r;

  logic [31:0] idle_r, period_r, last_sweep_r;
  logic [CW-1:0] count_r;
  nft_pkg::state_t st_r, st_nxt;
  logic [223:0] req_r;
  logic [AW:0] ptr_r;       // address issued to memory
  logic [AW-1:0] rd_idx_r;  // address of data now on read port
  logic rd_vld_r;
  logic [175:0] ent_q;
  logic [31:0] stamp_q;
  logic [175:0] hit_ent_r;
  logic free_found_r;
  logic [AW-1:0] free_idx_r;
  logic [1:0] status_r;

  logic mode;
  logic [7:0] proto;
  logic [31:0] sip, dip, tip, tag, now;
  logic [15:0] sport, dport, tport;
  assign mode  = req_r[0];
  assign proto = req_r[8:1];
  assign sip   = req_r[40:9];
  assign dip   = req_r[72:41];
  assign sport = req_r[88:73];
  assign dport = req_r[104:89];
  assign tip   = req_r[136:105];
  assign tport = req_r[152:137];
  assign tag   = req_r[184:153];
  assign now   = req_r[216:185];

  logic [95:0] key;
  always_comb begin
    if (!mode) key = {sip, tip, sport, tport};
    else key = {dip, sip, dport, sport};
  end

  logic match;
  assign match = rd_vld_r && valid_r[rd_idx_r] && (ent_q[175:80] == key);

  logic issuing;
  assign issuing = (st_r == nft_pkg::S_SCAN || st_r == nft_pkg::S_SWEEP) && ptr_r <= LAST;
  logic last_rd;
  assign last_rd = rd_vld_r && (rd_idx_r == LAST[AW-1:0]);

  logic expire;
  assign expire = st_r == nft_pkg::S_SWEEP && rd_vld_r && valid_r[rd_idx_r]
                  && (now - stamp_q) > idle_r;

  // An entry counts as free when it is invalid, or when the sweep is removing it.
  logic slot_free;
  assign slot_free = rd_vld_r && (st_r == nft_pkg::S_SCAN || st_r == nft_pkg::S_SWEEP)
                     && (!valid_r[rd_idx_r] || expire);

  always_ff @(posedge clk) begin
    if (issuing) begin
      ent_q <= ent_mem[ptr_r[AW-1:0]];
      stamp_q <= stamp_mem[ptr_r[AW-1:0]];
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      nft_pkg::S_IDLE: if (in_tvalid) begin
        st_nxt = (in_tdata[8:1] == nft_pkg::ProtoTcp) ? nft_pkg::S_SCAN : nft_pkg::S_DONE;
      end
      nft_pkg::S_SCAN: begin
        if (match) st_nxt = nft_pkg::S_DONE;
        else if (last_rd) begin
          if (mode) st_nxt = nft_pkg::S_DONE;
          else if ((now - last_sweep_r) > period_r) st_nxt = nft_pkg::S_SWEEP;
          else st_nxt = nft_pkg::S_FREE;
        end
      end
      nft_pkg::S_SWEEP: if (last_rd) st_nxt = nft_pkg::S_FREE;
      nft_pkg::S_FREE: st_nxt = nft_pkg::S_DONE;
      nft_pkg::S_DONE: if (out_tready) st_nxt = nft_pkg::S_IDLE;
      default: st_nxt = nft_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (st_r == nft_pkg::S_IDLE);
    out_tvalid = (st_r == nft_pkg::S_DONE);
  end

  logic [31:0] osip, odip, rtag;
  logic [15:0] osport, odport;
  always_comb begin
    osip = sip; odip = dip; osport = sport; odport = dport; rtag = '0;
    if (status_r == nft_pkg::StOk && proto == nft_pkg::ProtoTcp) begin
      if (!mode) begin
        odip = tip; odport = tport;
      end else begin
        osip = hit_ent_r[79:48]; osport = hit_ent_r[47:32]; rtag = hit_ent_r[31:0];
      end
    end
    out_tdata = {rtag, odport, osport, odip, osip, status_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nft_pkg::S_IDLE;
      valid_r <= '0;
      count_r <= '0;
      last_sweep_r <= '0;
      idle_r <= nft_pkg::IdleTimeoutRst;
      period_r <= nft_pkg::PurgePeriodRst;
      rd_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == nft_pkg::CfgIdleTimeout) idle_r <= cfg_wdata;
        else period_r <= cfg_wdata;
      end
      rd_vld_r <= issuing && !(st_r == nft_pkg::S_SCAN && match);
      if (expire) begin
        valid_r[rd_idx_r] <= 1'b0;
        count_r <= count_r - 1'b1;
      end
      if (st_r == nft_pkg::S_SWEEP && last_rd) last_sweep_r <= now;
      if (st_r == nft_pkg::S_FREE && count_r < CW'(FLOW_CAPACITY) && free_found_r) begin
        valid_r[free_idx_r] <= 1'b1;
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == nft_pkg::S_IDLE && in_tvalid) begin
      req_r <= in_tdata;
      status_r <= (in_tdata[8:1] == nft_pkg::ProtoTcp) ? nft_pkg::StOk : nft_pkg::StNotTcp;
      ptr_r <= '0;
    end else if (st_r == nft_pkg::S_SCAN && last_rd && !match) begin
      ptr_r <= '0;
      if (mode) status_r <= nft_pkg::StUnknown;
    end else if (issuing) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (issuing) rd_idx_r <= ptr_r[AW-1:0];
    if (st_r == nft_pkg::S_IDLE && in_tvalid) begin
      free_found_r <= 1'b0;
    end else if (slot_free && (!free_found_r || rd_idx_r < free_idx_r)) begin
      free_found_r <= 1'b1;
      free_idx_r <= rd_idx_r;
    end
    if (st_r == nft_pkg::S_SCAN && match) begin
      hit_ent_r <= ent_q;
      stamp_mem[rd_idx_r] <= now;
    end
    if (st_r == nft_pkg::S_FREE) begin
      if (count_r < CW'(FLOW_CAPACITY) && free_found_r) begin
        ent_mem[free_idx_r] <= {sip, tip, sport, tport, dip, dport, tag};
        stamp_mem[free_idx_r] <= now;
      end else begin
        status_r <= nft_pkg::StFull;
      end
    end
  end

  logic unused;
  assign unused = ^req_r[223:217];
endmodule
`default_nettype wire

/* tb/nat_flow_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_flow_table_test
// Self-checking bench for the flow table: TCP and non-TCP header requests go through a
// stream driver, results are compared field by field against a flow-table
// predictor kept in the bench, across idling phases and register settings.
// ----------------------------------------------------------------------------
module nat_flow_table_test;

  localparam int unsigned Capacity = nft_pkg::FlowCapacity;
  localparam longint CycleLimit = 40_000_000;

  typedef struct {
    logic        mode;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] target_ip;
    logic [15:0] target_port;
    logic [31:0] forward_tag;
    logic [31:0] now_seconds;
  } header_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] return_tag;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  nat_flow_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Bench copy of the table state and registers.
  logic        flow_live [Capacity];
  logic [31:0] flow_client [Capacity];
  logic [31:0] flow_server [Capacity];
  logic [31:0] flow_ports [Capacity];
  logic [47:0] flow_origin [Capacity];
  logic [31:0] flow_handle [Capacity];
  logic [31:0] flow_stamp [Capacity];
  int unsigned live_flows;
  logic [31:0] sweep_time;
  logic [31:0] idle_limit;
  logic [31:0] sweep_gap;

  header_t  pending_headers[$];
  verdict_t expected_verdicts[$];
  header_t  known_flows[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned full_seen = 0;
  int unsigned hits_seen = 0;
  longint cycles = 0;
  logic [31:0] clock_now = 32'd0;

  function automatic int lookup_flow(logic [31:0] cip, logic [31:0] sip, logic [31:0] ports);
    for (int i = 0; i < Capacity; i++)
      if (flow_live[i] && flow_client[i] == cip && flow_server[i] == sip &&
          flow_ports[i] == ports) return i;
    return -1;
  endfunction

  function automatic verdict_t rewrite_header(header_t h);
    verdict_t v;
    int idx;
    int slot;
    logic [31:0] ports;
    v.status = nft_pkg::StOk;
    v.src_ip = h.src_ip;
    v.dst_ip = h.dst_ip;
    v.src_port = h.src_port;
    v.dst_port = h.dst_port;
    v.return_tag = '0;
    if (h.protocol != nft_pkg::ProtoTcp) begin
      v.status = nft_pkg::StNotTcp;
    end else if (h.mode == 1'b0) begin
      ports = {h.src_port, h.target_port};
      idx = lookup_flow(h.src_ip, h.target_ip, ports);
      if (idx >= 0) begin
        flow_stamp[idx] = h.now_seconds;
      end else begin
        if (h.now_seconds - sweep_time > sweep_gap) begin
          for (int i = 0; i < Capacity; i++)
            if (flow_live[i] && (h.now_seconds - flow_stamp[i]) > idle_limit) begin
              flow_live[i] = 1'b0;
              if (live_flows > 0) live_flows--;
            end
          sweep_time = h.now_seconds;
        end
        slot = -1;
        if (live_flows < Capacity)
          for (int i = 0; i < Capacity; i++)
            if (!flow_live[i]) begin
              slot = i;
              break;
            end
        if (slot < 0) begin
          v.status = nft_pkg::StFull;
        end else begin
          flow_live[slot] = 1'b1;
          flow_client[slot] = h.src_ip;
          flow_server[slot] = h.target_ip;
          flow_ports[slot] = ports;
          flow_origin[slot] = {h.dst_ip, h.dst_port};
          flow_handle[slot] = h.forward_tag;
          flow_stamp[slot] = h.now_seconds;
          live_flows++;
        end
      end
      if (v.status == nft_pkg::StOk) begin
        v.dst_ip = h.target_ip;
        v.dst_port = h.target_port;
      end
    end else begin
      idx = lookup_flow(h.dst_ip, h.src_ip, {h.dst_port, h.src_port});
      if (idx < 0) begin
        v.status = nft_pkg::StUnknown;
      end else begin
        flow_stamp[idx] = h.now_seconds;
        v.src_ip = flow_origin[idx][47:16];
        v.src_port = flow_origin[idx][15:0];
        v.return_tag = flow_handle[idx];
      end
    end
    return v;
  endfunction

  function automatic logic [223:0] pack_header(header_t h);
    return {7'd0, h.now_seconds, h.forward_tag, h.target_port, h.target_ip,
            h.dst_port, h.src_port, h.dst_ip, h.src_ip, h.protocol, h.mode};
  endfunction

  // Driver: holds a request until it is taken, then pulls the next one.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_verdicts.push_back(rewrite_header(pending_headers.pop_front()));
      if (!in_tvalid || in_tready) begin
        if (pending_headers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pack_header(pending_headers[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.src_ip = out_tdata[33:2];
      got.dst_ip = out_tdata[65:34];
      got.src_port = out_tdata[81:66];
      got.dst_port = out_tdata[97:82];
      got.return_tag = out_tdata[129:98];
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_tdata);
      end else begin
        want = expected_verdicts.pop_front();
        checked++;
        if (got.status == nft_pkg::StFull) full_seen++;
        if (got.return_tag != 0) hits_seen++;
        if (got != want) begin
          errors++;
          if (errors < 40)
            $display("%0t: mismatch expected st=%0d %h %h %h %h tag=%h got st=%0d %h %h %h %h tag=%h",
                     $time, want.status, want.src_ip, want.dst_ip, want.src_port,
                     want.dst_port, want.return_tag, got.status, got.src_ip, got.dst_ip,
                     got.src_port, got.dst_port, got.return_tag);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("nat_flow_table_test: errors");
      $finish;
    end
  end

  function automatic header_t random_header();
    header_t h;
    h.mode = 1'($urandom_range(1));
    h.protocol = ($urandom_range(9) == 0) ? 8'($urandom) : nft_pkg::ProtoTcp;
    h.src_ip = $urandom;
    h.dst_ip = $urandom;
    h.src_port = 16'($urandom);
    h.dst_port = 16'($urandom);
    h.target_ip = $urandom;
    h.target_port = 16'($urandom);
    h.forward_tag = $urandom;
    h.now_seconds = clock_now;
    return h;
  endfunction

  task automatic queue_header(header_t h);
    pending_headers.push_back(h);
  endtask

  task automatic tick_clock();
    if ($urandom_range(29) == 0) clock_now = $urandom;
    else clock_now += $urandom_range(400);
  endtask

  task automatic queue_new_flow();
    header_t h;
    h = random_header();
    h.mode = 1'b0;
    h.protocol = nft_pkg::ProtoTcp;
    queue_header(h);
    known_flows.push_back(h);
    if (known_flows.size() > 48) void'(known_flows.pop_front());
  endtask

  // Mostly well-formed traffic: new flows, refreshes and returns of known ones.
  task automatic queue_mixed(int unsigned count);
    header_t h;
    header_t k;
    int unsigned pick;
    repeat (count) begin
      tick_clock();
      pick = $urandom_range(99);
      if (pick < 35 || known_flows.size() == 0) begin
        queue_new_flow();
      end else if (pick < 75) begin
        k = known_flows[$urandom_range(known_flows.size() - 1)];
        h = random_header();
        h.protocol = nft_pkg::ProtoTcp;
        h.mode = 1'b1;
        h.src_ip = k.target_ip;
        h.dst_ip = k.src_ip;
        h.src_port = k.target_port;
        h.dst_port = k.src_port;
        queue_header(h);
      end else if (pick < 88) begin
        k = known_flows[$urandom_range(known_flows.size() - 1)];
        h = random_header();
        h.protocol = nft_pkg::ProtoTcp;
        h.mode = 1'b0;
        h.src_ip = k.src_ip;
        h.src_port = k.src_port;
        h.target_ip = k.target_ip;
        h.target_port = k.target_port;
        queue_header(h);
      end else begin
        queue_header(random_header());
      end
    end
  endtask

  task automatic drain();
    while (pending_headers.size() != 0 || in_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nft_pkg::CfgIdleTimeout) idle_limit = value;
    else sweep_gap = value;
  endtask

  initial begin
    header_t h;
    for (int i = 0; i < Capacity; i++) flow_live[i] = 1'b0;
    live_flows = 0;
    sweep_time = '0;
    idle_limit = nft_pkg::IdleTimeoutRst;
    sweep_gap = nft_pkg::PurgePeriodRst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: non-TCP, all-ones and all-zero headers, hit, refresh, miss.
    h = random_header();
    h.protocol = 8'd0;
    queue_header(h);
    h.protocol = 8'hFF;
    h.mode = 1'b1;
    queue_header(h);
    h = '{1'b0, nft_pkg::ProtoTcp, '1, '1, '1, '1, '1, '1, '1, 32'd10};
    queue_header(h);
    h.now_seconds = 32'd20;
    queue_header(h);
    h = '{1'b1, nft_pkg::ProtoTcp, '1, '1, '1, '1, '0, '0, '0, 32'd30};
    queue_header(h);
    h = '{1'b0, nft_pkg::ProtoTcp, '0, '0, '0, '0, '0, '0, '0, 32'd40};
    queue_header(h);
    h = '{1'b1, nft_pkg::ProtoTcp, '0, '0, '0, '0, '1, '1, '1, 32'd50};
    queue_header(h);
    h.src_port = 16'h1234;
    queue_header(h);
    h.protocol = 8'd17;
    queue_header(h);
    // Time wrap: a sweep is due once the clock passes the purge period.
    clock_now = 32'hFFFF_FF00;
    queue_new_flow();
    clock_now = 32'd5000;
    queue_new_flow();
    queue_mixed(8);
    drain();

    write_reg(nft_pkg::CfgIdleTimeout, 32'd0);
    write_reg(nft_pkg::CfgPurgePeriod, 32'd0);
    queue_mixed(70);
    drain();

    send_idle_pct = 47;
    write_reg(nft_pkg::CfgIdleTimeout, 32'd500);
    write_reg(nft_pkg::CfgPurgePeriod, 32'd900);
    queue_mixed(70);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 47;
    write_reg(nft_pkg::CfgIdleTimeout, 32'hFFFF_FFFF);
    write_reg(nft_pkg::CfgPurgePeriod, 32'd200);
    queue_mixed(70);
    drain();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    write_reg(nft_pkg::CfgIdleTimeout, nft_pkg::IdleTimeoutRst);
    write_reg(nft_pkg::CfgPurgePeriod, nft_pkg::PurgePeriodRst);
    queue_mixed(70);
    drain();

    // Fill the table with sweeps disabled until it refuses new flows.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(nft_pkg::CfgIdleTimeout, 32'hFFFF_FFFF);
    write_reg(nft_pkg::CfgPurgePeriod, 32'hFFFF_FFFF);
    repeat (Capacity + 8) begin
      clock_now += $urandom_range(3);
      if ($urandom_range(19) == 0) queue_mixed(1);
      else queue_new_flow();
    end
    drain();

    // Then age everything out in one sweep and carry on.
    send_idle_pct = 38;
    recv_stall_pct = 38;
    write_reg(nft_pkg::CfgIdleTimeout, 32'd0);
    write_reg(nft_pkg::CfgPurgePeriod, 32'd0);
    clock_now += 32'd10;
    queue_new_flow();
    queue_mixed(40);
    drain();

    $display("checked %0d results over five idling phases and seven register settings;",
             checked);
    $display("%0d table-full refusals and %0d restored return flows seen", full_seen,
             hits_seen);
    if (errors == 0) begin
      $display("nat_flow_table_test: clean");
    end else begin
      $display("nat_flow_table_test: errors");
    end
    $finish;
  end
endmodule
